/* hdl/ips_pkg.sv */
// Shared types and constants for the interval profiler slot table.
// Used by the interfaces, the controller, the datapath and the top level.
package ips_pkg;

   localparam int ACTION_BITS = 2;
   localparam int SLOT_BITS   = 4;
   localparam int STAMP_BITS  = 48;
   localparam int OUT_BITS    = 48;
   localparam int TOTAL_BITS  = 64;
   localparam int COUNT_BITS  = 32;
   localparam int PERIOD_BITS = 16;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_STOP  = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd3;

   // status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_EXISTS   = 2'd1;
   localparam logic [1:0] STS_NOTFOUND = 2'd2;
   localparam logic [1:0] STS_UNUSED   = 2'd3;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch the input beat
      logic exec;       // run add/start/stop and load the status beat
      logic tick_start; // bump tick counter, rewind the walk
      logic rd;         // read slot memories at walk index
      logic diff;       // form the interval
      logic fold;       // fold interval into statistics
      logic div_start;  // start average division
      logic emit;       // load report beat, clear statistics
      logic adv;        // step the walk index
   } ips_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic out_free;
      logic cur_used;
      logic walk_end;
      logic report;
      logic div_done;
   } ips_stat_type;

   // clamp to the 48-bit output range
   function automatic logic [OUT_BITS-1:0] sat_out(input logic [TOTAL_BITS-1:0] v);
      logic [OUT_BITS-1:0] r;
      r = (v > TOTAL_BITS'(OUT_MAX)) ? OUT_MAX : v[OUT_BITS-1:0];
      return r;
   endfunction

endpackage

/* hdl/ips_if.sv */
// Channel interfaces of the interval profiler: request, response and register write.
// Depends on ips_pkg for field widths.
interface ips_req_if import ips_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [SLOT_BITS-1:0]   slot;
   logic [STAMP_BITS-1:0]  timestamp;
   modport source (output valid, action, slot, timestamp, input ready);
   modport sink   (input valid, action, slot, timestamp, output ready);
endinterface

interface ips_rsp_if import ips_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [1:0]           status;
   logic [SLOT_BITS-1:0] report_slot;
   logic [OUT_BITS-1:0]  average_ns;
   logic [OUT_BITS-1:0]  maximum_ns;
   logic                 last;
   modport source (output valid, kind, status, report_slot, average_ns, maximum_ns, last,
                   input ready);
   modport sink   (input valid, kind, status, report_slot, average_ns, maximum_ns, last,
                   output ready);
endinterface

interface ips_csr_if import ips_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PERIOD_BITS-1:0] report_period;
   modport source (output valid, report_period, input ready);
   modport sink   (input valid, report_period, output ready);
endinterface

/* hdl/interval_profiler_slots.sv */
// Interval profiler slot table: a table of profiling slots with per-slot interval statistics.
// Requests on req_ch: add, start, stop (slot, timestamp) or tick. Each add/start/stop gives one
// status beat on rsp_ch with last set. A tick folds fresh intervals into each used slot and,
// once the tick counter reaches report_period, sends one report beat per used slot in slot
// order (average and maximum), last on the final one, then clears the statistics.
// csr_ch writes report_period (reset value 1); it is always ready. It is to be written while
// idle; the block itself does not enforce this. The status beat of add/start/stop is loaded
// into the output register from the exec state, which waits while that register is full.
// A tick has a decode state, then walks every slot: the read state for an unused slot, read,
// diff and fold for a used slot, plus divide (64-step bit-serial divider) and emit if reported.
// One request is worked at a time; the next is accepted once the controller is idle,
// even while the last result beat still waits in the output register.
// When rsp_ch stalls the result beat holds in the output register and the walk waits.
// Reset (synchronous, active high) frees all slots, clears the tick counter and sets
// report_period back to 1; slot memories need no clearing since an add zeroes the slot
// before it is read.
// Depends on ips_pkg, ips_if, ips_ctrl, ips_dp and ips_div.
module interval_profiler_slots import ips_pkg::*; #(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_BITS  = 48
) (
   input  logic      clock,
   input  logic      reset,
   ips_req_if.sink   req_ch,
   ips_rsp_if.source rsp_ch,
   ips_csr_if.sink   csr_ch
);
   ips_cmd_type  cmd;
   ips_stat_type stat;

   assign csr_ch.ready = 1'b1;

   ips_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ips_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_ch.action),
      .req_slot          (req_ch.slot),
      .req_timestamp     (req_ch.timestamp),
      .csr_valid         (csr_ch.valid),
      .csr_report_period (csr_ch.report_period),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_kind          (rsp_ch.kind),
      .rsp_status        (rsp_ch.status),
      .rsp_report_slot   (rsp_ch.report_slot),
      .rsp_average_ns    (rsp_ch.average_ns),
      .rsp_maximum_ns    (rsp_ch.maximum_ns),
      .rsp_last          (rsp_ch.last)
   );
endmodule

/* hdl/ips_div.sv */
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on ips_pkg for widths.
module ips_div import ips_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TOTAL_BITS-1:0] dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [TOTAL_BITS-1:0] quotient
);
   localparam int CW = $clog2(TOTAL_BITS);

   logic                  busy_ff, busy_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [TOTAL_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   trial;

   // one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[TOTAL_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = COUNT_BITS'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[TOTAL_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_BITS-1:0];
            quo_in = {quo_ff[TOTAL_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(TOTAL_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* hdl/ips_dp.sv */
// Datapath of the interval profiler: slot memories, statistics fold, tick counter,
// output register. Depends on ips_pkg and instantiates ips_div.
module ips_dp import ips_pkg::*; #(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ips_cmd_type            cmd,
   output ips_stat_type           stat,
   input  logic [ACTION_BITS-1:0] req_action,
   input  logic [SLOT_BITS-1:0]   req_slot,
   input  logic [STAMP_BITS-1:0]  req_timestamp,
   input  logic                   csr_valid,
   input  logic [PERIOD_BITS-1:0] csr_report_period,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [1:0]             rsp_status,
   output logic [SLOT_BITS-1:0]   rsp_report_slot,
   output logic [OUT_BITS-1:0]    rsp_average_ns,
   output logic [OUT_BITS-1:0]    rsp_maximum_ns,
   output logic                   rsp_last
);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // registers
   logic [ACTION_BITS-1:0] action_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [TIME_BITS-1:0]   ts_ff;
   logic [PERIOD_BITS-1:0] period_ff, tick_ff, tick_in;
   logic                   report_ff, report_in;
   logic [SW-1:0]          walk_ff;
   logic [SLOT_COUNT-1:0]  used_ff, used_in, fresh_ff, fresh_in;

   // slot memories
   logic [TIME_BITS-1:0]  start_mem [SLOT_COUNT];
   logic [TIME_BITS-1:0]  stop_mem  [SLOT_COUNT];
   logic [TOTAL_BITS-1:0] total_mem [SLOT_COUNT];
   logic [TIME_BITS-1:0]  peak_mem  [SLOT_COUNT];
   logic [COUNT_BITS-1:0] cnt_mem   [SLOT_COUNT];

   logic [TIME_BITS-1:0]  rd_start_ff, rd_stop_ff, rd_peak_ff, d_ff;
   logic [TOTAL_BITS-1:0] rd_total_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [TOTAL_BITS-1:0] fold_total_ff, fold_total_in;
   logic [TIME_BITS-1:0]  fold_peak_ff, fold_peak_in;
   logic [COUNT_BITS-1:0] fold_cnt_ff, fold_cnt_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff, out_last_ff;
   logic [1:0]            out_status_ff;
   logic [SLOT_BITS-1:0]  out_slot_ff;
   logic [OUT_BITS-1:0]   out_avg_ff, out_max_ff;

   // write port
   logic                  start_we, stop_we, stats_we;
   logic [SW-1:0]         wr_addr;
   logic [TIME_BITS-1:0]  start_wd, stop_wd, peak_wd;
   logic [TOTAL_BITS-1:0] total_wd;
   logic [COUNT_BITS-1:0] cnt_wd;

   logic [SW-1:0]         slot_idx;
   logic                  slot_ok;
   logic [1:0]            exec_status;
   logic [PERIOD_BITS-1:0] tick_inc;
   logic [TOTAL_BITS:0]   sum;
   logic                  more_used;
   logic                  div_done;
   logic [TOTAL_BITS-1:0] div_q;

   assign slot_idx = SW'(slot_ff);
   assign slot_ok  = ({3'b000, slot_ff} < 7'(SLOT_COUNT));
   assign tick_inc = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;

   // any used slot after the walk index
   always_comb begin
      more_used = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (used_ff[i] && (i > int'(walk_ff))) more_used = 1'b1;
      end
   end

   // add/start/stop decision and memory writes
   always_comb begin
      used_in     = used_ff;
      fresh_in    = fresh_ff;
      exec_status = STS_NOTFOUND;
      start_we    = 1'b0;
      stop_we     = 1'b0;
      stats_we    = 1'b0;
      wr_addr     = walk_ff;
      start_wd    = '0;
      stop_wd     = '0;
      total_wd    = '0;
      peak_wd     = '0;
      cnt_wd      = '0;
      if (slot_ok) begin
         unique case (action_ff)
            ACT_ADD: begin
               if (used_ff[slot_idx]) exec_status = STS_EXISTS;
               else exec_status = STS_OK;
            end
            ACT_START, ACT_STOP: begin
               if (used_ff[slot_idx]) exec_status = STS_OK;
            end
            default: exec_status = STS_NOTFOUND;
         endcase
      end
      if (cmd.exec) begin
         wr_addr = slot_idx;
         if (exec_status == STS_OK) begin
            unique case (action_ff)
               ACT_ADD: begin
                  used_in[slot_idx]  = 1'b1;
                  fresh_in[slot_idx] = 1'b0;
                  start_we = 1'b1;
                  stop_we  = 1'b1;
                  stats_we = 1'b1;
               end
               ACT_START: begin
                  start_we = 1'b1;
                  start_wd = ts_ff;
               end
               ACT_STOP: begin
                  stop_we = 1'b1;
                  stop_wd = ts_ff;
                  fresh_in[slot_idx] = 1'b1;
               end
               default: ;
            endcase
         end
      end
      if (cmd.fold) begin
         fresh_in[walk_ff] = 1'b0;
         if (!report_ff) begin
            stats_we = 1'b1;
            total_wd = fold_total_in;
            peak_wd  = fold_peak_in;
            cnt_wd   = fold_cnt_in;
         end
      end
      // report clears the statistics
      if (cmd.emit) stats_we = 1'b1;
   end

   // fold of a fresh interval
   always_comb begin
      sum           = {1'b0, rd_total_ff} + (TOTAL_BITS + 1)'(d_ff);
      fold_total_in = rd_total_ff;
      fold_peak_in  = rd_peak_ff;
      fold_cnt_in   = rd_cnt_ff;
      if (fresh_ff[walk_ff]) begin
         fold_total_in = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
         if (d_ff > rd_peak_ff) fold_peak_in = d_ff;
         if (rd_cnt_ff != '1) fold_cnt_in = rd_cnt_ff + 1'b1;
      end
   end

   // tick counter and report flag
   always_comb begin
      tick_in   = tick_ff;
      report_in = report_ff;
      if (cmd.tick_start) begin
         report_in = (tick_inc >= period_ff);
         tick_in   = report_in ? '0 : tick_inc;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.exec || cmd.emit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         fresh_ff     <= '0;
         tick_ff      <= '0;
         report_ff    <= 1'b0;
         period_ff    <= PERIOD_BITS'(1);
         out_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         fresh_ff     <= fresh_in;
         tick_ff      <= tick_in;
         report_ff    <= report_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) period_ff <= csr_report_period;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         slot_ff   <= req_slot;
         ts_ff     <= TIME_BITS'(req_timestamp);
      end
      if (cmd.tick_start) walk_ff <= '0;
      else if (cmd.adv) walk_ff <= walk_ff + 1'b1;
      if (cmd.diff) d_ff <= rd_stop_ff - rd_start_ff;
      if (cmd.fold) begin
         fold_total_ff <= fold_total_in;
         fold_peak_ff  <= fold_peak_in;
         fold_cnt_ff   <= fold_cnt_in;
      end
      if (cmd.exec) begin
         out_kind_ff   <= KIND_STATUS;
         out_status_ff <= exec_status;
         out_slot_ff   <= slot_ff;
         out_avg_ff    <= '0;
         out_max_ff    <= '0;
         out_last_ff   <= 1'b1;
      end else if (cmd.emit) begin
         out_kind_ff   <= KIND_REPORT;
         out_status_ff <= STS_UNUSED;
         out_slot_ff   <= SLOT_BITS'(walk_ff);
         out_avg_ff    <= (fold_cnt_ff == '0) ? '0 : sat_out(div_q);
         out_max_ff    <= sat_out(TOTAL_BITS'(fold_peak_ff));
         out_last_ff   <= !more_used;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (start_we) start_mem[wr_addr] <= start_wd;
      if (stop_we)  stop_mem[wr_addr]  <= stop_wd;
      if (stats_we) begin
         total_mem[wr_addr] <= total_wd;
         peak_mem[wr_addr]  <= peak_wd;
         cnt_mem[wr_addr]   <= cnt_wd;
      end
      if (cmd.rd) begin
         rd_start_ff <= start_mem[walk_ff];
         rd_stop_ff  <= stop_mem[walk_ff];
         rd_total_ff <= total_mem[walk_ff];
         rd_peak_ff  <= peak_mem[walk_ff];
         rd_cnt_ff   <= cnt_mem[walk_ff];
      end
   end

   // divider loads the folded values in the same cycle as the fold
   ips_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (fold_total_in),
      .divisor  (fold_cnt_in),
      .done     (div_done),
      .quotient (div_q)
   );

   // status to controller
   assign stat.is_tick  = (action_ff == ACT_TICK);
   assign stat.out_free = !out_valid_ff || rsp_ready;
   assign stat.cur_used = used_ff[walk_ff];
   assign stat.walk_end = (walk_ff == SW'(SLOT_COUNT - 1));
   assign stat.report   = report_ff;
   assign stat.div_done = div_done;

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_report_slot = out_slot_ff;
   assign rsp_average_ns  = out_avg_ff;
   assign rsp_maximum_ns  = out_max_ff;
   assign rsp_last        = out_last_ff;
endmodule

/* hdl/ips_ctrl.sv */
// Controller of the interval profiler: sequences request handling and the tick walk.
// Depends on ips_pkg for the command and status structs.
module ips_ctrl import ips_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ips_stat_type stat,
   output ips_cmd_type  cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXEC  = 7'b0000010,
      ST_TREAD = 7'b0000100,
      ST_TDIFF = 7'b0001000,
      ST_TFOLD = 7'b0010000,
      ST_TDIV  = 7'b0100000,
      ST_TEMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next slot or end of walk
   function automatic state_type step_walk(input logic walk_end);
      return walk_end ? ST_IDLE : ST_TREAD;
   endfunction

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.is_tick) begin
               cmd.tick_start = 1'b1;
               state_in       = ST_TREAD;
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TREAD: begin
            if (stat.cur_used) begin
               cmd.rd   = 1'b1;
               state_in = ST_TDIFF;
            end else begin
               cmd.adv  = !stat.walk_end;
               state_in = step_walk(stat.walk_end);
            end
         end
         ST_TDIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_TFOLD;
         end
         ST_TFOLD: begin
            cmd.fold = 1'b1;
            if (stat.report) begin
               cmd.div_start = 1'b1;
               state_in      = ST_TDIV;
            end else begin
               cmd.adv  = !stat.walk_end;
               state_in = step_walk(stat.walk_end);
            end
         end
         ST_TDIV: begin
            if (stat.div_done) state_in = ST_TEMIT;
         end
         ST_TEMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.adv  = !stat.walk_end;
               state_in = step_walk(stat.walk_end);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

/* dv/ips_tb_if.sv */
// Testbench beat types for the interval profiler: one request beat and one result beat.
// Depends on ips_pkg for field widths; the channel interfaces come from hdl/ips_if.sv.
`timescale 1ns / 100ps
package ips_tb_types;
   import ips_pkg::*;
   // one input beat as the testbench sees it
   typedef struct {
      logic [ACTION_BITS-1:0] action;
      logic [SLOT_BITS-1:0]   slot;
      logic [STAMP_BITS-1:0]  timestamp;
   } req_beat_type;
   // one result beat
   typedef struct {
      logic                 kind;
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] report_slot;
      logic [OUT_BITS-1:0]  average_ns;
      logic [OUT_BITS-1:0]  maximum_ns;
      logic                 last;
   } rsp_beat_type;
endpackage

/* dv/interval_profiler_slots_tb.sv */
// Testbench for interval_profiler_slots: directed and random add/start/stop/tick traffic,
// with a slot-table predictor inside a small scoreboard class. Depends on ips_pkg, ips_if,
// ips_tb_types and the RTL.
`timescale 1ns / 100ps
module interval_profiler_slots_tb;
   import ips_pkg::*;
   import ips_tb_types::*;

   localparam int NSLOT = 16;

   // slot-table predictor and queue of expected result beats
   class profile_board;
      bit                  in_use    [NSLOT];
      logic [47:0]         t_start   [NSLOT];
      logic [47:0]         t_stop    [NSLOT];
      bit                  pending   [NSLOT];
      logic [63:0]         sum_ns    [NSLOT];
      logic [47:0]         peak_ns   [NSLOT];
      logic [31:0]         n_samples [NSLOT];
      logic [15:0]         ticks;
      logic [15:0]         period;
      rsp_beat_type        due_q[$];
      int                  errors;

      function new();
         for (int s = 0; s < NSLOT; s++) begin
            in_use[s] = 0; t_start[s] = 0; t_stop[s] = 0; pending[s] = 0;
            sum_ns[s] = 0; peak_ns[s] = 0; n_samples[s] = 0;
         end
         ticks = 0; period = 1; errors = 0;
      endfunction

      function logic [47:0] sat_avg(logic [63:0] v);
         return (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
      endfunction

      function void note_request(req_beat_type b);
         rsp_beat_type r;
         logic [47:0]  d;
         logic [64:0]  acc;
         int           first;
         bit           rep;
         r.average_ns = 0; r.maximum_ns = 0;
         if (b.action != ACT_TICK) begin
            r.kind = KIND_STATUS; r.report_slot = b.slot; r.last = 1;
            if (b.action == ACT_ADD) begin
               if (in_use[b.slot]) r.status = STS_EXISTS;
               else begin
                  in_use[b.slot] = 1; t_start[b.slot] = 0; t_stop[b.slot] = 0;
                  pending[b.slot] = 0; sum_ns[b.slot] = 0; peak_ns[b.slot] = 0;
                  n_samples[b.slot] = 0; r.status = STS_OK;
               end
            end else if (!in_use[b.slot]) r.status = STS_NOTFOUND;
            else if (b.action == ACT_START) begin
               t_start[b.slot] = b.timestamp; r.status = STS_OK;
            end else begin
               t_stop[b.slot] = b.timestamp; pending[b.slot] = 1; r.status = STS_OK;
            end
            due_q.push_back(r);
            return;
         end
         if (ticks != 16'hFFFF) ticks++;
         rep = ticks >= period;
         first = due_q.size();
         for (int s = 0; s < NSLOT; s++) begin
            if (!in_use[s]) continue;
            if (pending[s]) begin
               pending[s] = 0;
               d = t_stop[s] - t_start[s];
               acc = sum_ns[s] + d;
               sum_ns[s] = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
               if (d > peak_ns[s]) peak_ns[s] = d;
               if (n_samples[s] != 32'hFFFF_FFFF) n_samples[s]++;
            end
            if (!rep) continue;
            r.kind = KIND_REPORT; r.status = STS_UNUSED; r.report_slot = 4'(s); r.last = 0;
            r.average_ns = n_samples[s] ? sat_avg(sum_ns[s] / n_samples[s]) : 0;
            r.maximum_ns = peak_ns[s];
            due_q.push_back(r);
            sum_ns[s] = 0; peak_ns[s] = 0; n_samples[s] = 0;
         end
         if (due_q.size() > first) due_q[due_q.size()-1].last = 1;
         if (rep) ticks = 0;
      endfunction

      function void check_result(rsp_beat_type a);
         rsp_beat_type e;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat slot %0d", a.report_slot);
            return;
         end
         e = due_q.pop_front();
         if (a.kind !== e.kind || a.status !== e.status || a.report_slot !== e.report_slot ||
             a.average_ns !== e.average_ns || a.maximum_ns !== e.maximum_ns ||
             a.last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch exp k%0d s%0d slot%0d avg%0d max%0d l%0d",
                         " got k%0d s%0d slot%0d avg%0d max%0d l%0d"},
                  e.kind, e.status, e.report_slot, e.average_ns, e.maximum_ns, e.last,
                  a.kind, a.status, a.report_slot, a.average_ns, a.maximum_ns, a.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   ips_req_if req_ch ();
   ips_rsp_if rsp_ch ();
   ips_csr_if csr_ch ();

   interval_profiler_slots uut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   profile_board board = new();
   int  idle_pct  = 0;   // sender idle chance, percent
   int  stall_pct = 0;   // receiver stall chance, percent
   longint cycles = 0;
   logic [47:0] now_ns = 0;

   initial begin
      req_ch.valid = 0; req_ch.action = ACT_ADD; req_ch.slot = 0; req_ch.timestamp = 0;
      rsp_ch.ready = 0; csr_ch.valid = 0; csr_ch.report_period = 0;
   end

   // receiver: random stall, check on every accepted beat
   always @(posedge clock) begin
      rsp_beat_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a.kind = rsp_ch.kind; a.status = rsp_ch.status; a.report_slot = rsp_ch.report_slot;
         a.average_ns = rsp_ch.average_ns; a.maximum_ns = rsp_ch.maximum_ns;
         a.last = rsp_ch.last;
         board.check_result(a);
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > 3_000_000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // valid stays high after an accepted beat until the next idle cycle or drain
   task automatic send_beat(logic [1:0] act, logic [3:0] s, logic [47:0] ts);
      req_beat_type b;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.action <= act; req_ch.slot <= s; req_ch.timestamp <= ts;
      b.action = act; b.slot = s; b.timestamp = ts;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(b);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (board.due_q.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_period(logic [15:0] p);
      csr_ch.valid <= 1; csr_ch.report_period <= p;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.period = p;
      csr_ch.valid <= 0;
      @(posedge clock);
   endtask

   // one random request beat on a random slot, timestamps mostly rising
   task automatic random_item();
      int r;
      logic [3:0] s;
      logic [47:0] ts;
      r = $urandom_range(99);
      s = 4'($urandom_range(15));
      ts = 48'({$urandom, $urandom});
      if (r < 8)       send_beat(ACT_ADD, s, ts);
      else if (r < 40) begin
         now_ns = ($urandom_range(9) == 0) ? ts : now_ns + 48'($urandom_range(5000));
         send_beat(ACT_START, s, now_ns);
      end else if (r < 75) begin
         now_ns = ($urandom_range(9) == 0) ? ts : now_ns + 48'($urandom_range(100000));
         send_beat(ACT_STOP, s, now_ns);
      end else send_beat(ACT_TICK, s, ts);
   endtask

   initial begin
      int pcts[4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{19, 19}};
      logic [15:0] periods[4] = '{16'd0, 16'd3, 16'd1, 16'hFFFF};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty tick, not-found, add/exists, extremes, wrap interval
      send_beat(ACT_TICK, 4'h0, 48'd0);
      send_beat(ACT_START, 4'hF, 48'hFFFF_FFFF_FFFF);
      send_beat(ACT_STOP, 4'h0, 48'd0);
      send_beat(ACT_ADD, 4'h0, 48'd0);
      send_beat(ACT_ADD, 4'h0, 48'hFFFF_FFFF_FFFF);
      send_beat(ACT_ADD, 4'hF, 48'd0);
      send_beat(ACT_ADD, 4'h5, 48'd0);
      send_beat(ACT_START, 4'h0, 48'hFFFF_FFFF_FFFF);
      send_beat(ACT_STOP, 4'h0, 48'd10);
      send_beat(ACT_START, 4'hF, 48'd0);
      send_beat(ACT_STOP, 4'hF, 48'hFFFF_FFFF_FFFF);
      send_beat(ACT_TICK, 4'h0, 48'd0);
      send_beat(ACT_STOP, 4'h0, 48'd20);
      send_beat(ACT_TICK, 4'h0, 48'd0);
      send_beat(ACT_TICK, 4'h0, 48'd0);
      drain();
      write_period(16'd2);
      send_beat(ACT_STOP, 4'h5, 48'hAAAA_5555_AAAA);
      send_beat(ACT_STOP, 4'h0, 48'h5555_AAAA_5555);
      send_beat(ACT_TICK, 4'h0, 48'd0);
      send_beat(ACT_TICK, 4'h0, 48'd0);
      drain();

      // random phases over several periods and pacing
      for (int ph = 0; ph < 4; ph++) begin
         write_period(periods[ph]);
         idle_pct = pcts[ph][0]; stall_pct = pcts[ph][1];
         for (int i = 0; i < 113; i++) random_item();
         idle_pct = 0; stall_pct = 0;
         drain();
      end
      if (board.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // reset release ordering above is done at an edge with a nonblocking write
endmodule
